@@ hdl/periodic_soft_timer_bank_core_assert.svh @@
// assertion macros shared by the timer bank modules
// each module that uses them provides clk and rst_n
`ifndef PERIODIC_SOFT_TIMER_BANK_CORE_ASSERT_SVH
`define PERIODIC_SOFT_TIMER_BANK_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pst_pkg.sv @@
`default_nettype none

package pst_pkg;

    // bank size and derived widths
    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int TOTAL_W     = $clog2(TIMER_SLOTS + 1);

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int PERIOD_W = 32;
    localparam int MASK_W   = 16;
    localparam int ACTIVE_W = 5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SLOT_W-1:0] slot_t;

    // command codes on the input
    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_e;

    // classified operation
    typedef enum logic [2:0] {
        OP_CREATE,
        OP_DELETE,
        OP_START,
        OP_STOP,
        OP_TICK,
        OP_NONE
    } op_kind_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [IDX_W-1:0]    slot_index;
        logic [PERIOD_W-1:0] new_period;
    } pst_in_t;

    typedef struct packed {
        logic                create_ok;
        logic [IDX_W-1:0]    created_slot;
        logic [MASK_W-1:0]   fired_mask;
        logic [ACTIVE_W-1:0] active_count;
        logic                slot_running;
    } pst_out_t;

    typedef struct packed {
        op_kind_t            kind;
        logic                idx_ok;
        slot_t               slot;
        logic [PERIOD_W-1:0] period;
    } op_t;

    // occupied count to the result field width
    function automatic logic [ACTIVE_W-1:0] to_active(logic [TOTAL_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[ACTIVE_W-1:0];
    endfunction

    // slot number to the result field width
    function automatic logic [IDX_W-1:0] to_index(slot_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/pst_front.sv @@
`default_nettype none

module pst_front
    import pst_pkg::*;
(
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  pst_in_t cmd,
    output logic    push,
    output op_t     push_op,
    input  logic    q_full
);

    // take a transfer whenever the queue has room
    assign cmd_ready = !q_full;
    assign push      = cmd_valid && !q_full;

    // decode command and check the slot address
    always_comb
    begin
        push_op.idx_ok = ({28'd0, cmd.slot_index} < 32'(TIMER_SLOTS));
        push_op.slot   = slot_t'(cmd.slot_index);
        push_op.period = cmd.new_period;
        unique case (cmd.command)
            CMD_CREATE: push_op.kind = OP_CREATE;
            CMD_DELETE: push_op.kind = OP_DELETE;
            CMD_START:  push_op.kind = OP_START;
            CMD_STOP:   push_op.kind = OP_STOP;
            CMD_TICK:   push_op.kind = OP_TICK;
            default:    push_op.kind = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/pst_queue.sv @@
`default_nettype none

`include "periodic_soft_timer_bank_core_assert.svh"

module pst_queue
    import pst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  pop_op,
    output logic not_empty
);

    op_t                q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = q_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_op;
        end
    end

    `PST_ASSERT_NOW(a_no_pop_when_empty, pop, not_empty, "queue popped while empty")
    `PST_ASSERT_NOW(a_no_push_when_full, push, !full, "queue pushed while full")
    `PST_ASSERT_NEXT(a_push_fills, push && !pop, count_reg != '0, "push left queue empty")

endmodule

`default_nettype wire

@@ hdl/pst_back.sv @@
`default_nettype none

`include "periodic_soft_timer_bank_core_assert.svh"

module pst_back
    import pst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_not_empty,
    input  op_t      q_op,
    output logic     pop,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pst_out_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_LAST  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [TIMER_SLOTS-1:0]  used_reg, used_next;
    logic [TIMER_SLOTS-1:0]  enabled_reg, enabled_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    slot_t                   rd_idx_reg, rd_idx_next;
    logic                    proc_valid_reg, proc_valid_next;
    slot_t                   proc_idx_reg, proc_idx_next;
    logic [MASK_W-1:0]       fired_reg, fired_next;
    logic                    rsp_valid_reg;
    pst_out_t                rsp_reg, rsp_next;
    logic                    rsp_load;

    // period and counter memories
    logic [PERIOD_W-1:0]     period_mem [TIMER_SLOTS];
    logic [PERIOD_W-1:0]     count_mem  [TIMER_SLOTS];
    logic [PERIOD_W-1:0]     period_rd_reg;
    logic [PERIOD_W-1:0]     count_rd_reg;
    logic                    mem_rd_en;
    logic                    per_we;
    logic                    cnt_we;
    slot_t                   per_waddr;
    slot_t                   cnt_waddr;
    logic [PERIOD_W-1:0]     per_wdata;
    logic [PERIOD_W-1:0]     cnt_wdata;

    // lowest free slot
    logic [TIMER_SLOTS-1:0]  free_vec;
    logic [TIMER_SLOTS-1:0]  first_free_oh;
    slot_t                   free_slot;
    logic                    have_free;

    // sweep datapath
    logic                    live;
    logic [PERIOD_W-1:0]     count_inc;
    logic                    fire;
    logic [63:0]             fire_wide;
    logic [MASK_W-1:0]       fire_bit;

    logic                    rsp_free;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign pop       = (state_reg == S_IDLE) && q_not_empty && rsp_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // isolate the lowest clear bit of the occupancy vector, then encode it
    assign free_vec      = ~used_reg;
    assign have_free     = |free_vec;
    assign first_free_oh = free_vec & ((~free_vec) + TIMER_SLOTS'(1));

    always_comb
    begin
        free_slot = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            if (first_free_oh[i])
            begin
                free_slot = free_slot | slot_t'(i);
            end
        end
    end

    // one slot per cycle: increment and compare against the period
    always_comb
    begin
        live      = proc_valid_reg && used_reg[proc_idx_reg] && enabled_reg[proc_idx_reg];
        count_inc = count_rd_reg + 1'b1;
        fire      = live && (period_rd_reg != '0) && (count_inc == period_rd_reg);
        fire_wide = 64'(fire) << proc_idx_reg;
        fire_bit  = fire_wide[MASK_W-1:0];
    end

    // command execution and sweep sequencing
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        enabled_next    = enabled_reg;
        total_next      = total_reg;
        rd_idx_next     = rd_idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        fired_next      = fired_reg;
        rsp_load        = 1'b0;
        rsp_next        = '0;
        mem_rd_en       = 1'b0;
        per_we          = 1'b0;
        per_waddr       = free_slot;
        per_wdata       = q_op.period;
        cnt_we          = 1'b0;
        cnt_waddr       = q_op.slot;
        cnt_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    rsp_load = 1'b1;
                    case (q_op.kind)
                        OP_CREATE:
                        begin
                            if (have_free)
                            begin
                                used_next[free_slot]    = 1'b1;
                                enabled_next[free_slot] = 1'b0;
                                per_we                  = 1'b1;
                                cnt_we                  = 1'b1;
                                cnt_waddr               = free_slot;
                                total_next              = total_reg + 1'b1;
                                rsp_next.create_ok      = 1'b1;
                                rsp_next.created_slot   = to_index(free_slot);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (q_op.idx_ok && used_reg[q_op.slot])
                            begin
                                used_next[q_op.slot]    = 1'b0;
                                enabled_next[q_op.slot] = 1'b0;
                                cnt_we                  = 1'b1;
                                total_next              = total_reg - 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            if (q_op.idx_ok && used_reg[q_op.slot])
                            begin
                                enabled_next[q_op.slot] = 1'b1;
                            end
                        end
                        OP_STOP:
                        begin
                            if (q_op.idx_ok && used_reg[q_op.slot])
                            begin
                                enabled_next[q_op.slot] = 1'b0;
                                cnt_we                  = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            rsp_load    = 1'b0;
                            state_next  = S_SWEEP;
                            rd_idx_next = '0;
                            fired_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.active_count = to_active(total_next);
                    if ((q_op.kind == OP_DELETE || q_op.kind == OP_START ||
                         q_op.kind == OP_STOP) && q_op.idx_ok)
                    begin
                        rsp_next.slot_running = enabled_next[q_op.slot];
                    end
                end
            end
            S_SWEEP:
            begin
                mem_rd_en       = 1'b1;
                proc_valid_next = 1'b1;
                proc_idx_next   = rd_idx_reg;
                if (rd_idx_reg == slot_t'(TIMER_SLOTS - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next            = S_IDLE;
                rsp_load              = 1'b1;
                rsp_next.fired_mask   = fired_reg | fire_bit;
                rsp_next.active_count = to_active(total_reg);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // counter write-back of the slot read last cycle
        if (live)
        begin
            cnt_we     = 1'b1;
            cnt_waddr  = proc_idx_reg;
            cnt_wdata  = fire ? '0 : count_inc;
            fired_next = fired_reg | fire_bit;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            enabled_reg    <= '0;
            total_reg      <= '0;
            rd_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            fired_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            enabled_reg    <= enabled_next;
            total_reg      <= total_next;
            rd_idx_reg     <= rd_idx_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            fired_reg      <= fired_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // memory ports: one write each, one registered read
    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            period_mem[per_waddr] <= per_wdata;
        end
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (mem_rd_en)
        begin
            period_rd_reg <= period_mem[rd_idx_reg];
            count_rd_reg  <= count_mem[rd_idx_reg];
        end
    end

    `PST_ASSERT_NOW(a_total_matches_used, 1'b1, 32'(total_reg) == $countones(used_reg),
        "occupied count out of step with occupancy")
    `PST_ASSERT_NOW(a_enable_needs_used, 1'b1, (enabled_reg & ~used_reg) == '0,
        "free slot marked as enabled")
    `PST_ASSERT_NOW(a_sweep_rsp_empty, state_reg == S_SWEEP, !rsp_valid_reg,
        "result pending while sweeping")

endmodule

`default_nettype wire

@@ hdl/periodic_soft_timer_bank_core.sv @@
`default_nettype none

// Bank of TIMER_SLOTS periodic timer slots driven by create, delete, start, stop
// and tick commands, one result per command. Commands pass a two-entry queue
// into an execution unit; create, delete, start, stop and unknown codes are
// carried out there as they are popped, with the result registered. A tick
// sweeps the slots one per cycle through the period and counter memories,
// reading each slot's period and counter and writing the counter of each
// running slot back, then gives one result. The queue keeps taking commands
// while a sweep runs or a result waits to be taken, until it is full.
// No clearing pass is needed after reset.
module periodic_soft_timer_bank_core
    import pst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  pst_in_t  cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pst_out_t rsp
);

    logic push;
    op_t  push_op;
    logic q_full;
    logic pop;
    op_t  pop_op;
    logic q_not_empty;

    // command decode
    pst_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .push      (push),
        .push_op   (push_op),
        .q_full    (q_full)
    );

    // decoupling queue
    pst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (pop),
        .pop_op    (pop_op),
        .not_empty (q_not_empty)
    );

    // slot state and execution
    pst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_op        (pop_op),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
